/* rtl/sdc_pkg.sv */
// shared types, constants and helpers for the stereo dynamics compressor
// used by the sequencer top level, the root table builder and the divider

package sdc_pkg;

  localparam logic signed [31:0] DB96_Q16 = 32'sd6291456;
  localparam logic [35:0] DB_PER_OCT_Q16 = 36'd394566;
  localparam logic [35:0] OCT_PER_DB_Q32 = 36'd713378626;
  localparam int ROOT_COUNT = 16;
  localparam int DIV_BITS = 43;
  localparam int DVSR_BITS = 22;

  typedef enum logic [3:0] {
    CFG_THRESHOLD  = 4'd0,
    CFG_KNEE_WIDTH = 4'd1,
    CFG_COMP_SLOPE = 4'd2,
    CFG_EXP_SLOPE  = 4'd3,
    CFG_GATE_THR   = 4'd4,
    CFG_ATTACK     = 4'd5,
    CFG_RELEASE    = 4'd6,
    CFG_OUT_GAIN   = 4'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PEAK, S_SQ, S_SQW, S_MAG, S_MAGW, S_ENV0, S_ENVW, S_GC,
    S_CMPW, S_KX, S_KLO, S_KHI, S_KDIV, S_EXP, S_EXPW, S_CAP, S_GAIN0,
    S_GAINW, S_ROOT, S_ROOTW, S_SHN, S_OG, S_SL, S_SR, S_SRW, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RT_LOAD, RT_ITER, RT_DONE
  } rt_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // round half up by 2^30 and clamp to 24 bits
  function automatic logic [23:0] sat_round(input logic signed [71:0] v);
    logic signed [71:0] s;
    s = (v + 72'sd536870912) >>> 30;
    if (s > 72'sd8388607) return 24'h7FFFFF;
    else if (s < -72'sd8388608) return 24'h800000;
    else return s[23:0];
  endfunction

endpackage

/* rtl/sdc_mul.sv */
// shared signed multiplier with registered product
// depends on nothing

module sdc_mul (
  input  logic               clk,
  input  logic signed [35:0] a,
  input  logic signed [35:0] b,
  output logic signed [71:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* rtl/sdc_div.sv */
// serial restoring divider, one quotient bit a cycle
// depends on sdc_pkg

module sdc_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [sdc_pkg::DIV_BITS-1:0]        dividend,
  input  logic [sdc_pkg::DVSR_BITS-1:0]       divisor,
  output logic [sdc_pkg::DIV_BITS-1:0]        quotient,
  output sdc_pkg::div_stat_t                  stat
);

  logic [sdc_pkg::DVSR_BITS-1:0] rem;
  logic [sdc_pkg::DVSR_BITS:0]   trial;
  logic [5:0]                    cnt;

  assign trial = {rem, quotient[sdc_pkg::DIV_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= stat.busy && (cnt == 6'd1);
      if (start) begin
        quotient  <= dividend;
        rem       <= '0;
        cnt       <= 6'(sdc_pkg::DIV_BITS);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem      <= sdc_pkg::DVSR_BITS'(trial - {1'b0, divisor});
          quotient <= {quotient[sdc_pkg::DIV_BITS-2:0], 1'b1};
        end else begin
          rem      <= trial[sdc_pkg::DVSR_BITS-1:0];
          quotient <= {quotient[sdc_pkg::DIV_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) stat.busy <= 1'b0;
      end
    end
  end

endmodule

/* rtl/sdc_roots.sv */
// builds the table of q30 roots 2^-(2^-k), k = 1 to 16, after reset by serial square root
// depends on sdc_pkg

module sdc_roots (
  input  logic        clk,
  input  logic        rst,
  input  logic [3:0]  idx,
  output logic [30:0] root,
  output logic        ready
);

  sdc_pkg::rt_state_t state, state_next;
  logic [30:0] tab [sdc_pkg::ROOT_COUNT];
  logic [30:0] t;
  logic [60:0] v, r, bitv, rnew, vnew;
  logic [4:0]  j;
  logic [3:0]  k;

  assign root  = tab[idx];
  assign ready = (state == sdc_pkg::RT_DONE);
  assign bitv  = 61'd1 << {j, 1'b0};

  always_comb begin
    vnew = v;
    if (v >= r + bitv) begin
      vnew = v - (r + bitv);
      rnew = (r >> 1) + bitv;
    end else begin
      rnew = r >> 1;
    end
    state_next = state;
    case (state)
      sdc_pkg::RT_LOAD: state_next = sdc_pkg::RT_ITER;
      sdc_pkg::RT_ITER: begin
        if (j == 5'd0) state_next = (k == 4'd15) ? sdc_pkg::RT_DONE : sdc_pkg::RT_LOAD;
      end
      sdc_pkg::RT_DONE: state_next = sdc_pkg::RT_DONE;
      default: state_next = sdc_pkg::RT_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sdc_pkg::RT_LOAD;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t <= 31'd536870912;
      k <= '0;
    end else begin
      case (state)
        sdc_pkg::RT_LOAD: begin
          v <= {t, 30'd0};
          r <= '0;
          j <= 5'd29;
        end
        sdc_pkg::RT_ITER: begin
          v <= vnew;
          r <= rnew;
          j <= j - 5'd1;
          if (j == 5'd0) begin
            tab[k] <= rnew[30:0];
            t      <= rnew[30:0];
            k      <= k + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/stereo_dynamics_compressor.sv */
// stereo dynamics compressor: peak level, envelope, gain computer, gain apply
// one item at a time; the sequence steps through the squarings for the log, the root
// products and the knee division; s_tready rises in the cycle after the output register
// loads, and a stalled output holds it; after reset the root table is built with
// s_tready low; registers, envelope -96 dB and block peak restored; depends on sdc_pkg,
// sdc_mul, sdc_div, sdc_roots

module stereo_dynamics_compressor #(
  parameter int CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // left_in[23:0], right_in[47:24]
  input  logic        s_tlast,   // block_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // left_out, right_out, frame_compression_db,
                                 // block_peak_reduction_db, zero pad
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic signed [15:0] thr, gth;
  logic [13:0] kw;
  logic [15:0] cslope, eslope, atk, rel, og;

  // frame state
  sdc_pkg::state_t state, state_next;
  logic signed [23:0] ls, rs;
  logic blk;
  logic [23:0] p, la, ra;
  logic [4:0]  m, mpos, n;
  logic [31:0] y, ynorm, yy;
  logic [15:0] frac, f;
  logic [3:0]  cnt, idx;
  logic signed [31:0] lev, env;
  logic signed [25:0] bottom, top;
  logic signed [23:0] tq, gq;
  logic [21:0] wq;
  logic signed [26:0] comp, total, comp_cap, total_cap;
  logic [43:0] xx;
  logic [37:0] plo;
  logic [59:0] kprod;
  logic [30:0] gr, root;
  logic [33:0] g;
  logic [14:0] crep, bmax;
  logic [23:0] lo, ro;
  logic signed [35:0] ma, mb, mag0;
  logic signed [71:0] mp, magr, envn;
  logic div_start, roots_ready;
  logic [sdc_pkg::DIV_BITS-1:0] quot;
  sdc_pkg::div_stat_t div_st;

  sdc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  sdc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(kprod[59:17]),
    .divisor(wq), .quotient(quot), .stat(div_st)
  );

  sdc_roots u_roots (.clk(clk), .rst(rst), .idx(idx), .root(root), .ready(roots_ready));

  assign s_tready = (state == sdc_pkg::S_IDLE) && roots_ready;

  // peak magnitude and normalization
  assign la = ls[23] ? (~ls + 24'd1) : ls;
  assign ra = rs[23] ? (~rs + 24'd1) : rs;
  assign p  = (ra > la) ? ra : la;
  always_comb begin
    mpos = '0;
    for (int i = 0; i < 24; i++) begin
      if (p[i]) mpos = 5'(i);
    end
  end
  assign ynorm = 32'(p) << (5'd30 - mpos);
  assign yy    = mp[61:30];
  assign mag0  = 36'sd1507328 - $signed(36'({m, frac}));
  assign magr  = (mp + 72'sd32768) >>> 16;
  assign envn  = 72'(lev) + ((mp + 72'sd32768) >>> 16);

  // gain computer geometry in q16
  assign tq     = {thr, 8'd0};
  assign gq     = {gth, 8'd0};
  assign wq     = {kw, 8'd0};
  assign bottom = 26'(tq) - $signed(26'(wq >> 1));
  assign top    = 26'(tq) + $signed(26'(wq >> 1));
  assign kprod  = {mp[37:0], 22'd0} + 60'(plo);

  assign comp_cap  = (comp > 27'(sdc_pkg::DB96_Q16)) ? 27'(sdc_pkg::DB96_Q16) : comp;
  assign total_cap = (total > 27'(sdc_pkg::DB96_Q16)) ? 27'(sdc_pkg::DB96_Q16) : total;

  // sequencer: next state, multiplier operands and divider start
  always_comb begin
    state_next = state;
    ma = '0;
    mb = '0;
    div_start = 1'b0;
    case (state)
      sdc_pkg::S_IDLE:  if (s_tvalid && s_tready) state_next = sdc_pkg::S_PEAK;
      sdc_pkg::S_PEAK:  state_next = (p == 24'd0) ? sdc_pkg::S_ENV0 : sdc_pkg::S_SQ;
      sdc_pkg::S_SQ: begin
        ma = 36'(y);
        mb = 36'(y);
        state_next = sdc_pkg::S_SQW;
      end
      sdc_pkg::S_SQW:   state_next = (cnt == 4'd15) ? sdc_pkg::S_MAG : sdc_pkg::S_SQ;
      sdc_pkg::S_MAG: begin
        ma = mag0;
        mb = sdc_pkg::DB_PER_OCT_Q16;
        state_next = sdc_pkg::S_MAGW;
      end
      sdc_pkg::S_MAGW:  state_next = sdc_pkg::S_ENV0;
      sdc_pkg::S_ENV0: begin
        // attack when the level rises
        ma = (lev > env) ? 36'(atk) : 36'(rel);
        mb = 36'(env) - 36'(lev);
        state_next = sdc_pkg::S_ENVW;
      end
      sdc_pkg::S_ENVW:  state_next = sdc_pkg::S_GC;
      sdc_pkg::S_GC: begin
        if (34'(env) <= 34'(gq)) begin
          state_next = sdc_pkg::S_CAP;
        end else if (34'(env) >= 34'(top)) begin
          ma = 36'(env) - 36'(tq);
          mb = 36'(cslope);
          state_next = sdc_pkg::S_CMPW;
        end else if (wq != 22'd0 && 34'(env) > 34'(bottom)) begin
          ma = 36'(env) - 36'(bottom);
          mb = 36'(env) - 36'(bottom);
          state_next = sdc_pkg::S_KX;
        end else begin
          state_next = sdc_pkg::S_EXP;
        end
      end
      sdc_pkg::S_CMPW:  state_next = sdc_pkg::S_EXP;
      sdc_pkg::S_KX: begin
        ma = 36'(mp[21:0]);
        mb = 36'(cslope);
        state_next = sdc_pkg::S_KLO;
      end
      sdc_pkg::S_KLO: begin
        ma = 36'(xx[43:22]);
        mb = 36'(cslope);
        state_next = sdc_pkg::S_KHI;
      end
      sdc_pkg::S_KHI: begin
        div_start = 1'b1;
        state_next = sdc_pkg::S_KDIV;
      end
      sdc_pkg::S_KDIV:  if (div_st.done) state_next = sdc_pkg::S_EXP;
      sdc_pkg::S_EXP: begin
        // expander only below the knee and when nothing is compressed
        if (comp == 27'sd0 && eslope != 16'd0 && 34'(env) < 34'(bottom)) begin
          ma = 36'(bottom) - 36'(env);
          mb = 36'(eslope);
          state_next = sdc_pkg::S_EXPW;
        end else begin
          state_next = sdc_pkg::S_CAP;
        end
      end
      sdc_pkg::S_EXPW:  state_next = sdc_pkg::S_CAP;
      sdc_pkg::S_CAP:   state_next = sdc_pkg::S_GAIN0;
      sdc_pkg::S_GAIN0: begin
        ma = 36'(total);
        mb = sdc_pkg::OCT_PER_DB_Q32;
        state_next = sdc_pkg::S_GAINW;
      end
      sdc_pkg::S_GAINW: state_next = sdc_pkg::S_ROOT;
      sdc_pkg::S_ROOT: begin
        // one root multiply per set fraction bit
        if (f[4'd15 - idx]) begin
          ma = 36'(gr);
          mb = 36'(root);
          state_next = sdc_pkg::S_ROOTW;
        end else if (idx == 4'd15) begin
          state_next = sdc_pkg::S_SHN;
        end
      end
      sdc_pkg::S_ROOTW: state_next = (idx == 4'd15) ? sdc_pkg::S_SHN : sdc_pkg::S_ROOT;
      sdc_pkg::S_SHN: begin
        ma = 36'(gr >> n);
        mb = 36'(og);
        state_next = sdc_pkg::S_OG;
      end
      sdc_pkg::S_OG:    state_next = sdc_pkg::S_SL;
      sdc_pkg::S_SL: begin
        ma = 36'(ls);
        mb = 36'(g);
        state_next = sdc_pkg::S_SR;
      end
      sdc_pkg::S_SR: begin
        ma = 36'(rs);
        mb = 36'(g);
        state_next = sdc_pkg::S_SRW;
      end
      sdc_pkg::S_SRW:   state_next = sdc_pkg::S_OUT;
      sdc_pkg::S_OUT:   if (!m_tvalid || m_tready) state_next = sdc_pkg::S_IDLE;
      default: state_next = sdc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sdc_pkg::S_IDLE;
    else state <= state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= -16'sd5120;
      kw <= '0;
      cslope <= '0;
      eslope <= '0;
      gth <= -16'sd24576;
      atk <= 16'd60000;
      rel <= 16'd65000;
      og <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        sdc_pkg::CFG_THRESHOLD:  thr <= cfg_data;
        sdc_pkg::CFG_KNEE_WIDTH: kw <= cfg_data[13:0];
        sdc_pkg::CFG_COMP_SLOPE: cslope <= cfg_data;
        sdc_pkg::CFG_EXP_SLOPE:  eslope <= cfg_data;
        sdc_pkg::CFG_GATE_THR:   gth <= cfg_data;
        sdc_pkg::CFG_ATTACK:     atk <= cfg_data;
        sdc_pkg::CFG_RELEASE:    rel <= cfg_data;
        sdc_pkg::CFG_OUT_GAIN:   og <= cfg_data;
        default: ;
      endcase
    end
  end

  // envelope, block peak and output item
  always_ff @(posedge clk) begin
    if (rst) begin
      env      <= -sdc_pkg::DB96_Q16;
      bmax     <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      if (state == sdc_pkg::S_OUT && (!m_tvalid || m_tready)) begin
        // output register holds the item; block peak goes out with it, then restarts if the item ends a block
        m_tvalid <= 1'b1;
        m_tdata  <= {2'b00, bmax, crep, ro, lo};
        if (blk) bmax <= '0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        sdc_pkg::S_ENVW: env <= envn[31:0];
        sdc_pkg::S_CAP:  if (comp_cap[22:8] > bmax) bmax <= comp_cap[22:8];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      sdc_pkg::S_IDLE: begin
        if (s_tvalid && s_tready) begin
          ls  <= s_tdata[23:0];
          rs  <= (CHANNELS >= 2) ? s_tdata[47:24] : 24'd0;
          blk <= s_tlast;
        end
      end
      sdc_pkg::S_PEAK: begin
        frac <= '0;
        cnt  <= '0;
        m    <= mpos;
        y    <= ynorm;
        if (p == 24'd0) lev <= -sdc_pkg::DB96_Q16;
      end
      sdc_pkg::S_SQW: begin
        // squaring to two or more sets the next fraction bit and halves y
        if (yy[31]) begin
          y    <= yy >> 1;
          frac <= {frac[14:0], 1'b1};
        end else begin
          y    <= yy;
          frac <= {frac[14:0], 1'b0};
        end
        cnt <= cnt + 4'd1;
      end
      sdc_pkg::S_MAGW: begin
        if (magr > 72'(sdc_pkg::DB96_Q16)) lev <= -sdc_pkg::DB96_Q16;
        else lev <= -magr[31:0];
      end
      sdc_pkg::S_GC: begin
        comp  <= '0;
        total <= 27'(sdc_pkg::DB96_Q16);
      end
      // compression above the knee truncates
      sdc_pkg::S_CMPW: comp <= mp[42:16];
      sdc_pkg::S_KX:   xx <= mp[43:0];
      sdc_pkg::S_KLO:  plo <= mp[37:0];
      sdc_pkg::S_KDIV: if (div_st.done) comp <= quot[26:0];
      sdc_pkg::S_EXP:  total <= comp;
      sdc_pkg::S_EXPW: total <= (mp >>> 16) > 72'sd67108863 ? 27'sd67108863 : 27'(mp >>> 16);
      sdc_pkg::S_CAP: begin
        total <= total_cap;
        crep  <= comp_cap[22:8];
      end
      sdc_pkg::S_GAINW: begin
        n   <= mp[52:48];
        f   <= mp[47:32];
        gr  <= 31'd1073741824;
        idx <= '0;
      end
      sdc_pkg::S_ROOT:  if (!f[4'd15 - idx]) idx <= idx + 4'd1;
      sdc_pkg::S_ROOTW: begin
        gr  <= mp[60:30];
        idx <= idx + 4'd1;
      end
      sdc_pkg::S_OG:  g <= mp[45:12];
      sdc_pkg::S_SR:  lo <= sdc_pkg::sat_round(mp);
      sdc_pkg::S_SRW: ro <= sdc_pkg::sat_round(mp);
      default: ;
    endcase
  end

  // checks
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != sdc_pkg::S_IDLE) |-> !s_tready)
    else $error("input taken while a frame is in work");

  a_comp_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[62:48] <= 15'd24576))
    else $error("frame compression beyond 96 dB");

  a_peak_ge: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[77:63] >= m_tdata[62:48]))
    else $error("block peak below frame compression");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == sdc_pkg::S_KDIV))
    else $error("divider finished outside the knee step");

endmodule

/* tb/sdc_checker.sv */
// checker for the stereo dynamics compressor: tracks register writes, predicts each
// output item from every accepted input item and compares them field by field
// depends on sdc_pkg
`timescale 1ns / 100ps

module sdc_checker #(
  parameter int CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          outstanding
);

  logic signed [15:0] thr_db, gate_db;
  logic [13:0] knee_db;
  logic [15:0] comp_slope, exp_slope, atk_coeff, rel_coeff, out_gain;
  longint env_q16;
  logic [14:0] blk_peak;
  logic [79:0] frame_q[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // peak level in dB Q16, floored at -96 dB
  function automatic longint peak_level_q16(input logic [23:0] p);
    int m;
    logic [63:0] y;
    longint frac, mag;
    frac = 0;
    if (p == 0) return -longint'(sdc_pkg::DB96_Q16);
    m = 0;
    while (m < 31 && (p >> (m + 1)) != 0) m++;
    y = 64'(p) << (30 - m);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac = frac | 1;
      end
    end
    mag = (longint'(23) << 16) - ((longint'(m) << 16) | frac);
    mag = (mag * longint'(sdc_pkg::DB_PER_OCT_Q16) + 32768) >>> 16;
    if (mag > longint'(sdc_pkg::DB96_Q16)) mag = sdc_pkg::DB96_Q16;
    return -mag;
  endfunction

  // linear factor of a reduction in dB Q16, as Q30
  function automatic logic [63:0] atten_q30(input longint red);
    logic [63:0] l, n, f, r, t;
    l = (64'(red) * 64'(sdc_pkg::OCT_PER_DB_Q32)) >> 32;
    n = l >> 16;
    f = l & 64'hFFFF;
    r = 64'd1 << 30;
    t = 64'd1 << 29;
    for (int k = 1; k <= 16; k++) begin
      t = int_sqrt(t << 30);
      if ((f >> (16 - k)) & 1) r = (r * t) >> 30;
    end
    if (n > 31) n = 31;
    return r >> n;
  endfunction

  function automatic logic [23:0] scale_sat(input longint s, input longint g);
    longint v;
    v = (s * g + (longint'(1) << 29)) >>> 30;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // advances envelope and block peak, returns the packed output item
  function automatic logic [79:0] compress_frame(input logic [47:0] d, input logic last);
    longint l, r, lev, env, coeff, t, w, bottom, top, comp, total, g;
    logic [63:0] p, x;
    logic [14:0] comp_rep;
    logic [79:0] res;
    l = longint'(signed'(d[23:0]));
    r = longint'(signed'(d[47:24]));
    comp = 0;
    p = l < 0 ? -l : l;
    if (CHANNELS >= 2) begin
      if ((r < 0 ? -r : r) > p) p = r < 0 ? -r : r;
    end else begin
      r = 0;
    end
    lev = peak_level_q16(p[23:0]);
    env = env_q16;
    coeff = lev > env ? longint'(atk_coeff) : longint'(rel_coeff);
    env = lev + ((coeff * (env - lev) + 32768) >>> 16);
    env_q16 = env;

    if (env <= longint'(gate_db) * 256) begin
      total = sdc_pkg::DB96_Q16;
    end else begin
      t = longint'(thr_db) * 256;
      w = longint'(knee_db) * 256;
      bottom = t - w / 2;
      top = t + w / 2;
      if (env >= top) begin
        comp = ((env - t) * longint'(comp_slope)) >>> 16;
      end else if (w > 0 && env > bottom) begin
        x = env - bottom;
        comp = (x * x * 64'(comp_slope)) / (64'(w) * 2 * 65536);
      end
      total = comp;
      if (comp == 0 && exp_slope != 0 && env < bottom)
        total = ((bottom - env) * longint'(exp_slope)) >>> 16;
    end
    if (total > longint'(sdc_pkg::DB96_Q16)) total = sdc_pkg::DB96_Q16;
    if (comp > longint'(sdc_pkg::DB96_Q16)) comp = sdc_pkg::DB96_Q16;

    comp_rep = 15'(comp >> 8);
    if (comp_rep > blk_peak) blk_peak = comp_rep;
    g = (atten_q30(total) * 64'(out_gain)) >> 12;
    res = '0;
    res[23:0] = scale_sat(l, g);
    res[47:24] = CHANNELS >= 2 ? scale_sat(r, g) : 24'd0;
    res[62:48] = comp_rep;
    res[77:63] = blk_peak;
    if (last) blk_peak = 0;
    return res;
  endfunction

  always @(posedge clk) begin
    logic [79:0] want;
    if (rst) begin
      errors = 0;
      thr_db <= -16'sd5120;
      knee_db <= '0;
      comp_slope <= '0;
      exp_slope <= '0;
      gate_db <= -16'sd24576;
      atk_coeff <= 16'd60000;
      rel_coeff <= 16'd65000;
      out_gain <= 16'd4096;
      env_q16 = -longint'(sdc_pkg::DB96_Q16);
      blk_peak = 0;
      frame_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sdc_pkg::CFG_THRESHOLD:  thr_db <= cfg_data;
          sdc_pkg::CFG_KNEE_WIDTH: knee_db <= cfg_data[13:0];
          sdc_pkg::CFG_COMP_SLOPE: comp_slope <= cfg_data;
          sdc_pkg::CFG_EXP_SLOPE:  exp_slope <= cfg_data;
          sdc_pkg::CFG_GATE_THR:   gate_db <= cfg_data;
          sdc_pkg::CFG_ATTACK:     atk_coeff <= cfg_data;
          sdc_pkg::CFG_RELEASE:    rel_coeff <= cfg_data;
          sdc_pkg::CFG_OUT_GAIN:   out_gain <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) frame_q.push_back(compress_frame(s_tdata, s_tlast));
      if (m_tvalid && m_tready) begin
        if (frame_q.size() == 0) begin
          $display("%0t: unexpected output item %h", $time, m_tdata);
          errors++;
        end else begin
          want = frame_q.pop_front();
          if (m_tdata[23:0] !== want[23:0]) begin
            $display("%0t: left_out exp %h got %h", $time, want[23:0], m_tdata[23:0]);
            errors++;
          end
          if (m_tdata[47:24] !== want[47:24]) begin
            $display("%0t: right_out exp %h got %h", $time, want[47:24], m_tdata[47:24]);
            errors++;
          end
          if (m_tdata[62:48] !== want[62:48]) begin
            $display("%0t: frame_compression exp %0d got %0d", $time, want[62:48],
                     m_tdata[62:48]);
            errors++;
          end
          if (m_tdata[77:63] !== want[77:63]) begin
            $display("%0t: block_peak exp %0d got %0d", $time, want[77:63], m_tdata[77:63]);
            errors++;
          end
        end
      end
    end
    outstanding <= frame_q.size();
  end

endmodule

/* tb/tb.sv */
// top of the stereo dynamics compressor testbench: clock, reset, stimulus, verdict
// depends on sdc_pkg, the compressor rtl and sdc_checker
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT = 3000000;
  localparam logic [3:0] CFG_SPARE = 4'hF;  // beyond the register list, ignored

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;    // left_in, right_in
  logic        s_tlast = 0;     // block_end
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [79:0] m_tdata;         // left_out, right_out, frame_compression_db,
                                // block_peak_reduction_db, zero pad
  logic        cfg_we = 0;
  logic [3:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int errors, outstanding;
  int cycles = 0;
  int burst_left = 0;
  logic hold_req = 0;
  logic hold_done = 0;

  always #2 clk = ~clk;

  stereo_dynamics_compressor i_dut (.*);

  sdc_checker i_chk (.*);

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL stereo_dynamics_compressor");
      $finish;
    end
  end

  // receiver: stretches of steady, random and mostly stalled ready, plus one long hold
  initial begin
    int mode;
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 0;
        repeat (500) @(posedge clk);
        hold_done = 1;
      end else begin
        mode = $urandom_range(0, 2);
        repeat ($urandom_range(10, 60)) begin
          case (mode)
            0: m_tready <= 1;
            1: m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // offer one frame, with sender bursts and gaps in between
  task automatic send_frame(input logic [23:0] l, input logic [23:0] r, input logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1;
    s_tdata <= {r, l};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  // stop sending and let the block drain completely
  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] v[8], input logic spare);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= sdc_pkg::cfg_idx_t'(i);
      cfg_data <= v[i];
      @(posedge clk);
    end
    if (spare) begin
      cfg_index <= CFG_SPARE;
      cfg_data <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  // sample with a spread of levels, extremes now and then
  function automatic logic [23:0] rand_sample();
    logic [23:0] v;
    case ($urandom_range(0, 11))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return $urandom;
      default: begin
        v = $urandom_range(0, 8388607) >> $urandom_range(0, 22);
        return $urandom_range(0, 1) ? -v : v;
      end
    endcase
  endfunction

  initial begin
    logic [15:0] regs[8];
    logic [23:0] a;
    repeat (2) @(posedge clk);
    rst <= 0;

    // reset settings: silence is gated, full scale passes
    send_frame(24'h000000, 24'h000000, 0);
    send_frame(24'h7FFFFF, 24'h800000, 0);
    send_frame(24'h800000, 24'h7FFFFF, 0);
    send_frame(24'h000001, 24'hFFFFFF, 0);
    send_frame(24'h400000, 24'h000000, 1);
    send_frame(24'h000000, 24'h000000, 0);
    drain();

    // soft knee, compression, expander and gate all reachable
    regs = '{-16'sd2560, 16'd1536, 16'd49152, 16'd32768, -16'sd17920,
             16'd30000, 16'd60000, 16'd4096};
    write_regs(regs, 1);
    send_frame(24'h7FFFFF, 24'h7FFFFF, 0);
    send_frame(24'h7FFFFF, 24'h000000, 0);
    send_frame(24'h000000, 24'h800000, 0);
    send_frame(24'h080000, 24'hF80000, 1);
    send_frame(24'h040000, 24'h020000, 0);
    send_frame(24'h001000, 24'h000800, 0);
    send_frame(24'h000010, 24'h000000, 0);
    send_frame(24'h000000, 24'h000000, 0);
    send_frame(24'h000000, 24'h000000, 1);
    send_frame(24'h7FFFFF, 24'h800000, 1);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: regs = '{16'h8000, 16'd12288, 16'hFFFF, 16'hFFFF, 16'h8000,
                    16'd0, 16'hFFFF, 16'hFFFF};
        1: regs = '{16'h7FFF, 16'd0, 16'd0, 16'd0, 16'h7FFF,
                    16'hFFFF, 16'd0, 16'd0};
        2: regs = '{-16'sd7680, 16'h3FFF, 16'hFFFF, 16'd0, 16'h8000,
                    16'd0, 16'd0, 16'd8192};
        default: begin
          regs[sdc_pkg::CFG_THRESHOLD] = $urandom_range(0, 4) == 0 ? $urandom
                                         : -$urandom_range(0, 15360);
          regs[sdc_pkg::CFG_KNEE_WIDTH] = $urandom_range(0, 5) == 0
                                          ? $urandom_range(0, 16383)
                                          : $urandom_range(0, 12288);
          regs[sdc_pkg::CFG_COMP_SLOPE] = $urandom;
          regs[sdc_pkg::CFG_EXP_SLOPE] = $urandom_range(0, 2) == 0 ? 16'd0 : $urandom;
          regs[sdc_pkg::CFG_GATE_THR] = $urandom_range(0, 4) == 0 ? $urandom
                                        : -$urandom_range(10240, 24576);
          regs[sdc_pkg::CFG_ATTACK] = $urandom;
          regs[sdc_pkg::CFG_RELEASE] = $urandom;
          regs[sdc_pkg::CFG_OUT_GAIN] = $urandom_range(0, 4) == 0 ? $urandom
                                        : $urandom_range(0, 16383);
        end
      endcase
      write_regs(regs, ph == 4);
      // long receiver hold while frames keep coming
      if (ph == 5) hold_req <= 1;
      for (int i = 0; i < 68; i++) begin
        a = rand_sample();
        // mostly correlated channels, sometimes independent
        send_frame(a, $urandom_range(0, 2) == 0 ? rand_sample() : a >>> $urandom_range(0, 3),
                   $urandom_range(0, 9) == 0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS stereo_dynamics_compressor");
    end else begin
      $display("FAIL stereo_dynamics_compressor");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sdc_pkg.sv
rtl/sdc_mul.sv
rtl/sdc_div.sv
rtl/sdc_roots.sv
rtl/stereo_dynamics_compressor.sv
tb/sdc_checker.sv
tb/tb.sv
